// File: src/msbr_pkg.sv
// ----------------------------------------------------------------------------
// msbr_pkg
// Shared types, constants and codes for the mono to stereo balance restorer.
// ----------------------------------------------------------------------------
package msbr_pkg;

    localparam int SAMPLE_BITS      = 24;
    localparam int LATENCY_BITS_DEF = 16;
    localparam int POWER_W          = 49;
    localparam int COEFF_W          = 32;
    localparam int GAIN_W           = 18;
    localparam int LEVEL_W          = 25;
    localparam int CFG_W            = 49;
    localparam int CFG_IDX_W        = 2;

    localparam logic [COEFF_W-1:0] BALANCE_COEFF_RST = 32'd171799;
    localparam logic [COEFF_W-1:0] OBSERVE_COEFF_RST = 32'd25769803;
    localparam logic [POWER_W-1:0] BALANCE_FLOOR_RST = 49'd188;
    localparam logic [POWER_W-1:0] POWER_FLOOR       = 49'd28147;
    localparam logic [GAIN_W-1:0]  GAIN_ONE          = 18'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LATENCY       = 2'd0,
        REG_BALANCE_COEFF = 2'd1,
        REG_OBSERVE_COEFF = 2'd2,
        REG_BALANCE_FLOOR = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] processed_sample;
        logic signed [SAMPLE_BITS-1:0] dry_left;
        logic signed [SAMPLE_BITS-1:0] dry_right;
        logic                          dry_valid;
        logic                          block_last;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
        logic                          out_last;
    } frame_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_LAT_DEC,
        OP_MUL_SUM,
        OP_MUL_L,
        OP_MUL_R,
        OP_SQ_END,
        OP_ENV_DIFF,
        OP_ENV_MHI,
        OP_ENV_MLO,
        OP_ENV_ACC,
        OP_ENV_WR,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_SQRT_END,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_GAIN_L,
        OP_GAIN_R,
        OP_GAIN_END,
        OP_OUT_LOAD
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LAT,
        S_SQ_SUM,
        S_SQ_L,
        S_SQ_R,
        S_SQ_END,
        S_ENV_DIFF,
        S_ENV_MHI,
        S_ENV_MLO,
        S_ENV_ACC,
        S_ENV_WR,
        S_OBS,
        S_SQRT_INIT,
        S_SQRT_STEP,
        S_SQRT_END,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_END,
        S_GAIN_L,
        S_GAIN_R,
        S_GAIN_END,
        S_OUT
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] sel;
    } dp_cmd_t;

    typedef struct packed {
        logic lat_zero;
        logic dry_valid;
        logic observable;
        logic total_zero;
    } dp_status_t;

endpackage

// File: src/msbr_ctrl.sv
// ----------------------------------------------------------------------------
// msbr_ctrl
// Sequencer: steps the datapath through squares, envelopes, square roots,
// divisions and gain products, and owns the request handshakes.
// ----------------------------------------------------------------------------
module msbr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    output logic                  frame_valid,
    input  logic                  frame_stall,
    input  msbr_pkg::dp_status_t  status,
    output msbr_pkg::dp_cmd_t     cmd
);

    msbr_pkg::state_t state_reg;
    msbr_pkg::state_t state_next;
    logic [1:0]       sel_reg;
    logic [1:0]       sel_next;
    logic [4:0]       cnt_reg;
    logic [4:0]       cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free     = !out_valid_reg || !frame_stall;
    assign frame_valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msbr_pkg::S_IDLE;
            sel_reg       <= 2'd0;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && frame_stall;
        case (state_reg)
            msbr_pkg::S_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = msbr_pkg::S_LAT;
                end
            end
            msbr_pkg::S_LAT:
            begin
                if (!status.lat_zero || !status.dry_valid)
                begin
                    state_next = msbr_pkg::S_GAIN_L;
                end
                else
                begin
                    state_next = msbr_pkg::S_SQ_SUM;
                end
            end
            msbr_pkg::S_SQ_SUM: state_next = msbr_pkg::S_SQ_L;
            msbr_pkg::S_SQ_L:   state_next = msbr_pkg::S_SQ_R;
            msbr_pkg::S_SQ_R:   state_next = msbr_pkg::S_SQ_END;
            msbr_pkg::S_SQ_END:
            begin
                sel_next   = 2'd0;
                state_next = msbr_pkg::S_ENV_DIFF;
            end
            msbr_pkg::S_ENV_DIFF: state_next = msbr_pkg::S_ENV_MHI;
            msbr_pkg::S_ENV_MHI:  state_next = msbr_pkg::S_ENV_MLO;
            msbr_pkg::S_ENV_MLO:  state_next = msbr_pkg::S_ENV_ACC;
            msbr_pkg::S_ENV_ACC:  state_next = msbr_pkg::S_ENV_WR;
            msbr_pkg::S_ENV_WR:
            begin
                case (sel_reg)
                    2'd0:
                    begin
                        sel_next   = 2'd1;
                        state_next = msbr_pkg::S_ENV_DIFF;
                    end
                    2'd1:
                    begin
                        state_next = msbr_pkg::S_OBS;
                    end
                    2'd2:
                    begin
                        sel_next   = 2'd3;
                        state_next = msbr_pkg::S_ENV_DIFF;
                    end
                    default:
                    begin
                        sel_next   = 2'd0;
                        state_next = msbr_pkg::S_SQRT_INIT;
                    end
                endcase
            end
            msbr_pkg::S_OBS:
            begin
                if (status.observable)
                begin
                    sel_next   = 2'd2;
                    state_next = msbr_pkg::S_ENV_DIFF;
                end
                else
                begin
                    state_next = msbr_pkg::S_GAIN_L;
                end
            end
            msbr_pkg::S_SQRT_INIT:
            begin
                cnt_next   = 5'd24;
                state_next = msbr_pkg::S_SQRT_STEP;
            end
            msbr_pkg::S_SQRT_STEP:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = msbr_pkg::S_SQRT_END;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            msbr_pkg::S_SQRT_END:
            begin
                if (sel_reg == 2'd0)
                begin
                    sel_next   = 2'd1;
                    state_next = msbr_pkg::S_SQRT_INIT;
                end
                else
                begin
                    sel_next   = 2'd0;
                    state_next = msbr_pkg::S_DIV_INIT;
                end
            end
            msbr_pkg::S_DIV_INIT:
            begin
                if (status.total_zero)
                begin
                    state_next = msbr_pkg::S_GAIN_L;
                end
                else
                begin
                    cnt_next   = 5'd17;
                    state_next = msbr_pkg::S_DIV_STEP;
                end
            end
            msbr_pkg::S_DIV_STEP:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = msbr_pkg::S_DIV_END;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            msbr_pkg::S_DIV_END:
            begin
                if (sel_reg == 2'd0)
                begin
                    sel_next   = 2'd1;
                    state_next = msbr_pkg::S_DIV_INIT;
                end
                else
                begin
                    state_next = msbr_pkg::S_GAIN_L;
                end
            end
            msbr_pkg::S_GAIN_L:   state_next = msbr_pkg::S_GAIN_R;
            msbr_pkg::S_GAIN_R:   state_next = msbr_pkg::S_GAIN_END;
            msbr_pkg::S_GAIN_END: state_next = msbr_pkg::S_OUT;
            msbr_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = msbr_pkg::S_IDLE;
                end
            end
            default: state_next = msbr_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op       = msbr_pkg::OP_NONE;
        cmd.sel      = sel_reg;
        sample_stall = (state_reg != msbr_pkg::S_IDLE);
        case (state_reg)
            msbr_pkg::S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.op = msbr_pkg::OP_LOAD;
                end
            end
            msbr_pkg::S_LAT:
            begin
                if (!status.lat_zero)
                begin
                    cmd.op = msbr_pkg::OP_LAT_DEC;
                end
            end
            msbr_pkg::S_SQ_SUM:    cmd.op = msbr_pkg::OP_MUL_SUM;
            msbr_pkg::S_SQ_L:      cmd.op = msbr_pkg::OP_MUL_L;
            msbr_pkg::S_SQ_R:      cmd.op = msbr_pkg::OP_MUL_R;
            msbr_pkg::S_SQ_END:    cmd.op = msbr_pkg::OP_SQ_END;
            msbr_pkg::S_ENV_DIFF:  cmd.op = msbr_pkg::OP_ENV_DIFF;
            msbr_pkg::S_ENV_MHI:   cmd.op = msbr_pkg::OP_ENV_MHI;
            msbr_pkg::S_ENV_MLO:   cmd.op = msbr_pkg::OP_ENV_MLO;
            msbr_pkg::S_ENV_ACC:   cmd.op = msbr_pkg::OP_ENV_ACC;
            msbr_pkg::S_ENV_WR:    cmd.op = msbr_pkg::OP_ENV_WR;
            msbr_pkg::S_SQRT_INIT: cmd.op = msbr_pkg::OP_SQRT_INIT;
            msbr_pkg::S_SQRT_STEP: cmd.op = msbr_pkg::OP_SQRT_STEP;
            msbr_pkg::S_SQRT_END:  cmd.op = msbr_pkg::OP_SQRT_END;
            msbr_pkg::S_DIV_INIT:
            begin
                if (!status.total_zero)
                begin
                    cmd.op = msbr_pkg::OP_DIV_INIT;
                end
            end
            msbr_pkg::S_DIV_STEP:  cmd.op = msbr_pkg::OP_DIV_STEP;
            msbr_pkg::S_DIV_END:   cmd.op = msbr_pkg::OP_DIV_END;
            msbr_pkg::S_GAIN_L:    cmd.op = msbr_pkg::OP_GAIN_L;
            msbr_pkg::S_GAIN_R:    cmd.op = msbr_pkg::OP_GAIN_R;
            msbr_pkg::S_GAIN_END:  cmd.op = msbr_pkg::OP_GAIN_END;
            msbr_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    cmd.op = msbr_pkg::OP_OUT_LOAD;
                end
            end
            default: cmd.op = msbr_pkg::OP_NONE;
        endcase
    end

endmodule

// File: src/msbr_datapath.sv
// ----------------------------------------------------------------------------
// msbr_datapath
// Configuration, envelope state, shared multiplier, bit-serial square root,
// restoring divider and output saturation.
// ----------------------------------------------------------------------------
module msbr_datapath
#(
    parameter int LATENCY_BITS = msbr_pkg::LATENCY_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  msbr_pkg::sample_t                    sample,
    output msbr_pkg::frame_t                     frame,
    input  logic                                 cfg_write,
    input  logic [msbr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [msbr_pkg::CFG_W-1:0]           cfg_data,
    input  msbr_pkg::dp_cmd_t                    cmd,
    output msbr_pkg::dp_status_t                 status
);

    localparam int SB   = msbr_pkg::SAMPLE_BITS;
    localparam int PW   = msbr_pkg::POWER_W;
    localparam int GW   = msbr_pkg::GAIN_W;
    localparam int LW   = msbr_pkg::LEVEL_W;
    localparam int SHR  = (SB >= 24) ? SB - 24 : 0;
    localparam int SHL  = (SB >= 24) ? 0 : 24 - SB;
    localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (SB - 1)) - 66'sd1;
    localparam logic signed [65:0] SAT_LO = -(66'sd1 <<< (SB - 1));

    // configuration
    logic [msbr_pkg::COEFF_W-1:0] balance_coeff_reg;
    logic [msbr_pkg::COEFF_W-1:0] observe_coeff_reg;
    logic [PW-1:0]                balance_floor_reg;

    // state
    logic [LATENCY_BITS-1:0] lat_reg;
    logic [PW-1:0]           env_mono_reg;
    logic [PW-1:0]           env_stereo_reg;
    logic [PW-1:0]           env_left_reg;
    logic [PW-1:0]           env_right_reg;
    logic [GW-1:0]           lg_reg;
    logic [GW-1:0]           rg_reg;

    // working registers
    logic signed [SB-1:0]    proc_reg;
    logic signed [23:0]      l_reg;
    logic signed [23:0]      r_reg;
    logic                    dry_reg;
    logic                    last_reg;
    logic [PW-1:0]           mono_pow_reg;
    logic [PW-1:0]           stereo_pow_reg;
    logic [PW-1:0]           lp_reg;
    logic [PW-1:0]           rp_reg;
    logic [PW-1:0]           d_reg;
    logic                    up_reg;
    logic [PW:0]             acc_reg;
    logic signed [65:0]      prod_reg;
    logic [2*LW-1:0]         sq_val_reg;
    logic [LW:0]             sq_rem_reg;
    logic [LW-1:0]           sq_root_reg;
    logic [LW-1:0]           llev_reg;
    logic [LW-1:0]           rlev_reg;
    logic [42:0]             div_rem_reg;
    logic [42:0]             div_dvs_reg;
    logic [GW-1:0]           div_q_reg;
    logic signed [SB-1:0]    outl_reg;
    logic signed [SB-1:0]    outr_reg;
    msbr_pkg::frame_t        frame_reg;

    // combinational
    logic signed [31:0]      l_ext;
    logic signed [31:0]      r_ext;
    logic signed [23:0]      l_q23;
    logic signed [23:0]      r_q23;
    logic signed [24:0]      sum;
    logic signed [32:0]      mul_a;
    logic signed [32:0]      mul_b;
    logic [PW-1:0]           env_cur;
    logic [PW-1:0]           env_tgt;
    logic [msbr_pkg::COEFF_W-1:0] coeff;
    logic [PW-1:0]           floor_val;
    logic [PW:0]             env_sum;
    logic [PW-1:0]           env_new;
    logic [PW:0]             rp_new;
    logic [PW:0]             stereo_sum;
    logic [32:0]             lo_round;
    logic [56:0]             mono_x100;
    logic [56:0]             menv_x100;
    logic                    observable;
    logic [LW:0]             total;
    logic [LW+2:0]           sq_r2;
    logic [LW+2:0]           sq_trial;
    logic [42:0]             div_num;

    function automatic logic signed [SB-1:0] sat(input logic signed [65:0] p);
        logic signed [65:0] s;
        s = (p + 66'sd32768) >>> 16;
        if (s < SAT_LO)
        begin
            s = SAT_LO;
        end
        else if (s > SAT_HI)
        begin
            s = SAT_HI;
        end
        return s[SB-1:0];
    endfunction

    assign l_ext = 32'(sample.dry_left);
    assign r_ext = 32'(sample.dry_right);
    assign l_q23 = 24'((l_ext >>> SHR) <<< SHL);
    assign r_q23 = 24'((r_ext >>> SHR) <<< SHL);
    assign sum   = 25'(l_reg) + 25'(r_reg);

    // envelope operand selection
    always_comb
    begin
        case (cmd.sel)
            2'd0:
            begin
                env_cur = env_mono_reg;
                env_tgt = mono_pow_reg;
            end
            2'd1:
            begin
                env_cur = env_stereo_reg;
                env_tgt = stereo_pow_reg;
            end
            2'd2:
            begin
                env_cur = env_left_reg;
                env_tgt = lp_reg;
            end
            default:
            begin
                env_cur = env_right_reg;
                env_tgt = rp_reg;
            end
        endcase
        coeff     = cmd.sel[1] ? balance_coeff_reg : observe_coeff_reg;
        floor_val = cmd.sel[1] ? balance_floor_reg : msbr_pkg::POWER_FLOOR;
    end

    assign env_sum  = up_reg ? ({1'b0, env_cur} + acc_reg) : ({1'b0, env_cur} - acc_reg);
    assign env_new  = (env_sum[PW-1:0] < floor_val) ? '0 : env_sum[PW-1:0];
    assign rp_new   = {prod_reg[PW-2:0], 2'b00};
    assign stereo_sum = {1'b0, lp_reg} + rp_new;
    assign lo_round = 33'((prod_reg[63:0] + 64'h8000_0000) >> 32);

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            msbr_pkg::OP_MUL_SUM:
            begin
                mul_a = 33'(sum);
                mul_b = 33'(sum);
            end
            msbr_pkg::OP_MUL_L:
            begin
                mul_a = 33'(l_reg);
                mul_b = 33'(l_reg);
            end
            msbr_pkg::OP_MUL_R:
            begin
                mul_a = 33'(r_reg);
                mul_b = 33'(r_reg);
            end
            msbr_pkg::OP_ENV_MHI:
            begin
                mul_a = $signed({16'd0, d_reg[PW-1:32]});
                mul_b = $signed({1'b0, coeff});
            end
            msbr_pkg::OP_ENV_MLO:
            begin
                mul_a = $signed({1'b0, d_reg[31:0]});
                mul_b = $signed({1'b0, coeff});
            end
            msbr_pkg::OP_GAIN_L:
            begin
                mul_a = 33'(proc_reg);
                mul_b = $signed({15'd0, lg_reg});
            end
            msbr_pkg::OP_GAIN_R:
            begin
                mul_a = 33'(proc_reg);
                mul_b = $signed({15'd0, rg_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // observability: p >= floor(s / 100) is 100 * p + 100 > s
    assign mono_x100 = {2'b0, mono_pow_reg, 6'b0} + {3'b0, mono_pow_reg, 5'b0}
                     + {6'b0, mono_pow_reg, 2'b0} + 57'd100;
    assign menv_x100 = {2'b0, env_mono_reg, 6'b0} + {3'b0, env_mono_reg, 5'b0}
                     + {6'b0, env_mono_reg, 2'b0} + 57'd100;
    assign observable = (mono_pow_reg >= msbr_pkg::POWER_FLOOR)
                     && (mono_x100 > {8'b0, stereo_pow_reg})
                     && (env_mono_reg >= msbr_pkg::POWER_FLOOR)
                     && (menv_x100 > {8'b0, env_stereo_reg});

    assign total    = {1'b0, llev_reg} + {1'b0, rlev_reg};
    assign sq_r2    = {sq_rem_reg, sq_val_reg[2*LW-1:2*LW-2]};
    assign sq_trial = {1'b0, sq_root_reg, 2'b01};
    assign div_num  = 43'({(cmd.sel[0] ? rlev_reg : llev_reg), 17'd0}) + 43'(total >> 1);

    assign status.lat_zero   = (lat_reg == '0);
    assign status.dry_valid  = dry_reg;
    assign status.observable = observable;
    assign status.total_zero = (total == '0);

    assign frame = frame_reg;

    // configuration and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            balance_coeff_reg <= msbr_pkg::BALANCE_COEFF_RST;
            observe_coeff_reg <= msbr_pkg::OBSERVE_COEFF_RST;
            balance_floor_reg <= msbr_pkg::BALANCE_FLOOR_RST;
            lat_reg           <= '0;
            env_mono_reg      <= '0;
            env_stereo_reg    <= '0;
            env_left_reg      <= '0;
            env_right_reg     <= '0;
            lg_reg            <= msbr_pkg::GAIN_ONE;
            rg_reg            <= msbr_pkg::GAIN_ONE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                msbr_pkg::REG_LATENCY:
                begin
                    lat_reg        <= LATENCY_BITS'(cfg_data[15:0]);
                    env_mono_reg   <= '0;
                    env_stereo_reg <= '0;
                    env_left_reg   <= '0;
                    env_right_reg  <= '0;
                    lg_reg         <= msbr_pkg::GAIN_ONE;
                    rg_reg         <= msbr_pkg::GAIN_ONE;
                end
                msbr_pkg::REG_BALANCE_COEFF: balance_coeff_reg <= cfg_data[31:0];
                msbr_pkg::REG_OBSERVE_COEFF: observe_coeff_reg <= cfg_data[31:0];
                msbr_pkg::REG_BALANCE_FLOOR: balance_floor_reg <= cfg_data;
                default: ;
            endcase
        end
        else
        begin
            case (cmd.op)
                msbr_pkg::OP_LAT_DEC: lat_reg <= lat_reg - LATENCY_BITS'(1);
                msbr_pkg::OP_ENV_WR:
                begin
                    case (cmd.sel)
                        2'd0:    env_mono_reg   <= env_new;
                        2'd1:    env_stereo_reg <= env_new;
                        2'd2:    env_left_reg   <= env_new;
                        default: env_right_reg  <= env_new;
                    endcase
                end
                msbr_pkg::OP_DIV_END:
                begin
                    if (cmd.sel[0])
                    begin
                        rg_reg <= div_q_reg;
                    end
                    else
                    begin
                        lg_reg <= div_q_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            msbr_pkg::OP_LOAD:
            begin
                proc_reg <= sample.processed_sample;
                l_reg    <= l_q23;
                r_reg    <= r_q23;
                dry_reg  <= sample.dry_valid;
                last_reg <= sample.block_last;
            end
            msbr_pkg::OP_MUL_L: mono_pow_reg <= prod_reg[PW-1:0];
            msbr_pkg::OP_MUL_R: lp_reg <= {prod_reg[PW-3:0], 2'b00};
            msbr_pkg::OP_SQ_END:
            begin
                rp_reg         <= rp_new[PW-1:0];
                stereo_pow_reg <= stereo_sum[PW:1];
            end
            msbr_pkg::OP_ENV_DIFF:
            begin
                up_reg <= (env_tgt >= env_cur);
                d_reg  <= (env_tgt >= env_cur) ? env_tgt - env_cur : env_cur - env_tgt;
            end
            msbr_pkg::OP_ENV_MLO: acc_reg <= prod_reg[PW:0];
            msbr_pkg::OP_ENV_ACC: acc_reg <= acc_reg + (PW+1)'(lo_round);
            msbr_pkg::OP_SQRT_INIT:
            begin
                sq_val_reg  <= {1'b0, (cmd.sel[0] ? env_right_reg : env_left_reg)};
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            msbr_pkg::OP_SQRT_STEP:
            begin
                sq_val_reg <= {sq_val_reg[2*LW-3:0], 2'b00};
                if (sq_r2 >= sq_trial)
                begin
                    sq_rem_reg  <= (LW+1)'(sq_r2 - sq_trial);
                    sq_root_reg <= {sq_root_reg[LW-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg  <= sq_r2[LW:0];
                    sq_root_reg <= {sq_root_reg[LW-2:0], 1'b0};
                end
            end
            msbr_pkg::OP_SQRT_END:
            begin
                if (cmd.sel[0])
                begin
                    rlev_reg <= sq_root_reg;
                end
                else
                begin
                    llev_reg <= sq_root_reg;
                end
            end
            msbr_pkg::OP_DIV_INIT:
            begin
                div_rem_reg <= div_num;
                div_dvs_reg <= {total, 17'd0};
                div_q_reg   <= '0;
            end
            msbr_pkg::OP_DIV_STEP:
            begin
                div_dvs_reg <= div_dvs_reg >> 1;
                if (div_rem_reg >= div_dvs_reg)
                begin
                    div_rem_reg <= div_rem_reg - div_dvs_reg;
                    div_q_reg   <= {div_q_reg[GW-2:0], 1'b1};
                end
                else
                begin
                    div_q_reg   <= {div_q_reg[GW-2:0], 1'b0};
                end
            end
            msbr_pkg::OP_GAIN_R:   outl_reg <= sat(prod_reg);
            msbr_pkg::OP_GAIN_END: outr_reg <= sat(prod_reg);
            msbr_pkg::OP_OUT_LOAD:
            begin
                frame_reg.out_left  <= outl_reg;
                frame_reg.out_right <= outr_reg;
                frame_reg.out_last  <= last_reg;
            end
            default: ;
        endcase
    end

endmodule

// File: src/mono_to_stereo_balance_restorer.sv
// ----------------------------------------------------------------------------
// mono_to_stereo_balance_restorer
// Restores stereo balance to a processed mono stream from dry stereo frames.
//
//   channel  ports                               direction  width
//   sample   sample_valid / sample_stall / sample  in       74
//   frame    frame_valid / frame_stall / frame     out      49
//   config   cfg_write / cfg_index / cfg_data      in       2 + 49
//
// one request at a time: with latency counting down or no dry frame it only
// scales; with mono not observable it also updates the mono and stereo envelopes;
// else the full update runs, skipping the divisions when both levels are zero
// the bit-serial square root (25 steps) and divider (18 steps) per side set
// the long path; the shared multiplier takes one product per cycle
// reset clears envelopes, gains to unity and latency count to zero
// a finished frame waits in the output register while the next request runs
// ----------------------------------------------------------------------------
module mono_to_stereo_balance_restorer
#(
    parameter int LATENCY_BITS = msbr_pkg::LATENCY_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  msbr_pkg::sample_t              sample,
    output logic                           frame_valid,
    input  logic                           frame_stall,
    output msbr_pkg::frame_t               frame,
    input  logic                           cfg_write,
    input  logic [msbr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [msbr_pkg::CFG_W-1:0]     cfg_data
);

    msbr_pkg::dp_cmd_t    cmd;
    msbr_pkg::dp_status_t status;

    msbr_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .status       (status),
        .cmd          (cmd)
    );

    msbr_datapath #(.LATENCY_BITS(LATENCY_BITS)) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .frame     (frame),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: sim/tb_mono_to_stereo_balance_restorer.sv
// ----------------------------------------------------------------------------
// tb_mono_to_stereo_balance_restorer
// Self-checking bench for the balance restorer. A bit-exact predictor tracks
// the power envelopes, levels and gains of each request. Directed rows cover
// the extremes and the special cases, followed by random frames under
// changing settings and sender and receiver idling. Every frame is compared
// field by field, in order.
// ----------------------------------------------------------------------------
module tb_mono_to_stereo_balance_restorer;

    import msbr_pkg::*;

    localparam int          IDLE_LIMIT = 20000;
    localparam logic [63:0] PMASK      = (64'd1 << 49) - 64'd1;

    typedef struct {
        sample_t    s;
        bit         typed;
        frame_t     f;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    sample_t              sample = '0;
    logic                 frame_valid;
    logic                 frame_stall = 1'b0;
    frame_t               frame;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int                   sender_idle_pct;
    int                   receiver_stall_pct;
    int                   mismatches;
    int                   quiet_cycles;
    frame_t               pending_frames[$];
    dir_row_t             dir_rows[$];

    // predictor state
    logic [63:0] lat_frames, bal_coeff, obs_coeff, bal_floor;
    logic [63:0] lat_left, mono_env, stereo_env, left_env, right_env;
    logic [63:0] gain_l, gain_r;

    mono_to_stereo_balance_restorer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [63:0] env_step(logic [63:0] cur, logic [63:0] target,
                                             logic [63:0] c, logic [63:0] fl);
        logic [63:0] d;
        logic [63:0] sc;
        logic [63:0] nx;
        d  = (target >= cur) ? target - cur : cur - target;
        sc = (d >> 32) * c + (((d & 64'hFFFF_FFFF) * c + 64'h8000_0000) >> 32);
        nx = ((target >= cur) ? cur + sc : cur - sc) & PMASK;
        return (nx < fl) ? 64'd0 : nx;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] scale_sample(longint s, logic [63:0] g);
        longint p;
        p = (s * longint'(g) + 32768) >>> 16;
        if (p < -(longint'(1) << (SAMPLE_BITS-1))) p = -(longint'(1) << (SAMPLE_BITS-1));
        if (p > (longint'(1) << (SAMPLE_BITS-1)) - 1) p = (longint'(1) << (SAMPLE_BITS-1)) - 1;
        return p[SAMPLE_BITS-1:0];
    endfunction

    function automatic void clear_balance();
        lat_left   = lat_frames;
        mono_env   = 0;
        stereo_env = 0;
        left_env   = 0;
        right_env  = 0;
        gain_l     = GAIN_ONE;
        gain_r     = GAIN_ONE;
    endfunction

    function automatic frame_t restore_balance(sample_t s);
        frame_t      f;
        longint      l, r, sum;
        logic [63:0] mono_pow, lp, rp, stereo_pow, inst_fl, env_fl, llev, rlev, total;
        if (lat_left > 0)
            lat_left = lat_left - 1;
        else if (s.dry_valid)
        begin
            l          = longint'(s.dry_left);
            r          = longint'(s.dry_right);
            sum        = l + r;
            mono_pow   = sum * sum;
            lp         = (l * l) << 2;
            rp         = (r * r) << 2;
            stereo_pow = (lp + rp) >> 1;
            mono_env   = env_step(mono_env, mono_pow, obs_coeff, POWER_FLOOR);
            stereo_env = env_step(stereo_env, stereo_pow, obs_coeff, POWER_FLOOR);
            inst_fl    = stereo_pow / 100;
            if (inst_fl < POWER_FLOOR) inst_fl = POWER_FLOOR;
            env_fl     = stereo_env / 100;
            if (env_fl < POWER_FLOOR) env_fl = POWER_FLOOR;
            if (mono_pow >= inst_fl && mono_env >= env_fl)
            begin
                left_env  = env_step(left_env, lp, bal_coeff, bal_floor);
                right_env = env_step(right_env, rp, bal_coeff, bal_floor);
                llev      = floor_sqrt(left_env);
                rlev      = floor_sqrt(right_env);
                total     = llev + rlev;
                if (total > 0)
                begin
                    gain_l = ((llev << 17) + (total >> 1)) / total;
                    gain_r = ((rlev << 17) + (total >> 1)) / total;
                end
            end
        end
        f.out_left  = scale_sample(longint'(s.processed_sample), gain_l);
        f.out_right = scale_sample(longint'(s.processed_sample), gain_r);
        f.out_last  = s.block_last;
        return f;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        case (idx)
            REG_LATENCY:
            begin
                lat_frames = value & 64'hFFFF;
                clear_balance();
            end
            REG_BALANCE_COEFF: bal_coeff = value & 64'hFFFF_FFFF;
            REG_OBSERVE_COEFF: obs_coeff = value & 64'hFFFF_FFFF;
            REG_BALANCE_FLOOR: bal_floor = value & PMASK;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // request sent at the falling edge, held until accepted
    task automatic send(sample_t s, bit typed, frame_t f);
        frame_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        predicted = restore_balance(s);
        pending_frames.push_back(typed ? f : predicted);
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (200) @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] sat(longint v);
        if (v > 8388607) return 24'sd8388607;
        if (v < -8388608) return -24'sd8388608;
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic sample_t random_request();
        sample_t s;
        int      mode;
        longint  l;
        s    = sample_t'({$urandom, $urandom, $urandom});
        mode = $urandom_range(99);
        if ($urandom_range(9) == 0)
            s.processed_sample = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
        if (mode < 70)
        begin
            s.dry_valid = 1'b1;
            l           = longint'(s.dry_left) >>> $urandom_range(22);
            s.dry_left  = l[SAMPLE_BITS-1:0];
            if ($urandom_range(3) == 0)
                s.dry_right = sat(-l + longint'($urandom_range(3)) - 1);
            else
                s.dry_right = sat((l * longint'($urandom_range(320))) / 128);
        end
        else if (mode < 85)
            s.dry_valid = 1'b0;
        return s;
    endfunction

    task automatic random_phase(int count, int idle_pct, int stall_pct, bit pause);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if (pause && i == count / 2)
                drain();
            send(random_request(), 1'b0, '0);
        end
        drain();
    endtask

    task automatic add_row(longint ps, longint dl, longint dr, bit dv, bit last,
                           bit typed, longint el, longint er);
        dir_row_t row;
        row.s.processed_sample = ps[SAMPLE_BITS-1:0];
        row.s.dry_left         = dl[SAMPLE_BITS-1:0];
        row.s.dry_right        = dr[SAMPLE_BITS-1:0];
        row.s.dry_valid        = dv;
        row.s.block_last       = last;
        row.typed              = typed;
        row.f.out_left         = el[SAMPLE_BITS-1:0];
        row.f.out_right        = er[SAMPLE_BITS-1:0];
        row.f.out_last         = last;
        dir_rows.push_back(row);
    endtask

    always @(negedge clk)
        frame_stall <= ($urandom_range(99) < receiver_stall_pct);

    always @(posedge clk)
    begin
        if (frame_valid && !frame_stall)
        begin
            if (pending_frames.size() == 0)
                report("unexpected frame", frame.out_left, 0);
            else
            begin
                if (frame.out_left !== pending_frames[0].out_left)
                    report("out_left", frame.out_left, pending_frames[0].out_left);
                if (frame.out_right !== pending_frames[0].out_right)
                    report("out_right", frame.out_right, pending_frames[0].out_right);
                if (frame.out_last !== pending_frames[0].out_last)
                    report("out_last", frame.out_last, pending_frames[0].out_last);
                void'(pending_frames.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (frame_valid && !frame_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        mismatches         = 0;
        quiet_cycles       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        lat_frames         = 0;
        bal_coeff          = BALANCE_COEFF_RST;
        obs_coeff          = OBSERVE_COEFF_RST;
        bal_floor          = BALANCE_FLOOR_RST;
        clear_balance();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unity gains after reset: output equals the sample
        add_row( 8388607, 0, 0, 0, 1, 1,  8388607,  8388607);
        add_row(-8388608, 0, 0, 0, 0, 1, -8388608, -8388608);
        add_row(       0, 0, 0, 0, 1, 1,        0,        0);
        add_row(       1, 0, 0, 0, 0, 1,        1,        1);
        add_row(      -1, 0, 0, 0, 1, 1,       -1,       -1);
        // silent dry frame, then unobservable mono
        add_row( 4000000, 0, 0, 1, 0, 1,  4000000,  4000000);
        add_row( 4000000, 8388607, -8388607, 1, 0, 0, 0, 0);
        add_row(-4000000, -8388608, 8388607, 1, 1, 0, 0, 0);
        // left only, clamping at gain two, then full scale both, right only and full scale both
        add_row( 8388607, 8388607, 0, 1, 0, 0, 0, 0);
        add_row( 8388607, 0, 0, 0, 1, 0, 0, 0);
        add_row(-8388608, 0, 0, 0, 0, 0, 0, 0);
        add_row( 5000000, -8388608, -8388608, 1, 1, 0, 0, 0);
        add_row( 5000000, 0, 8388607, 1, 0, 0, 0, 0);
        add_row(-8388608, 0, -8388608, 1, 1, 0, 0, 0);
        add_row( 8388607, 8388607, 8388607, 1, 0, 0, 0, 0);
        add_row(    1000, 1, 1, 1, 1, 0, 0, 0);
        add_row(  -12345, -8388608, 8388607, 0, 0, 0, 0, 0);
        foreach (dir_rows[i])
            send(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].f);
        drain();

        write_reg(REG_BALANCE_COEFF, 64'hFFFF_FFFF);
        write_reg(REG_OBSERVE_COEFF, 64'hFFFF_FFFF);
        write_reg(REG_BALANCE_FLOOR, 64'd0);
        write_reg(REG_LATENCY, 64'd3);
        random_phase(400, 31, 75, 1'b1);

        write_reg(REG_BALANCE_COEFF, 64'd0);
        write_reg(REG_BALANCE_FLOOR, 64'd1 << 48);
        write_reg(REG_LATENCY, 64'd0);
        random_phase(100, 31, 75, 1'b0);

        write_reg(REG_LATENCY, 64'd65535);
        random_phase(30, 31, 75, 1'b0);

        write_reg(REG_LATENCY, 64'd0);
        write_reg(REG_BALANCE_COEFF, {32'd0, $urandom});
        write_reg(REG_OBSERVE_COEFF, {32'd0, $urandom});
        write_reg(REG_BALANCE_FLOOR, 64'd188);
        random_phase(400, 75, 31, 1'b0);

        write_reg(REG_BALANCE_COEFF, 64'h1000_0000);
        write_reg(REG_OBSERVE_COEFF, OBSERVE_COEFF_RST);
        write_reg(REG_BALANCE_FLOOR, BALANCE_FLOOR_RST);
        write_reg(REG_LATENCY, 64'd1);
        random_phase(250, 0, 0, 1'b0);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
src/msbr_pkg.sv
src/msbr_ctrl.sv
src/msbr_datapath.sv
src/mono_to_stereo_balance_restorer.sv
sim/tb_mono_to_stereo_balance_restorer.sv
